>>> rtl/hex_byte_list_parser_macros.svh
// Assertion macros for the hex byte list parser checker.
`ifndef HEX_BYTE_LIST_PARSER_MACROS_SVH
`define HEX_BYTE_LIST_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HBL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbl check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbl check failed");

`endif

>>> rtl/hbl_pkg.sv
// Package for the hex byte list parser: codes, result types and character decode.
`timescale 1ns / 1ps
package hbl_pkg;

  // Result queue depth (power of two, at least 2)
  localparam int unsigned RESULT_DEPTH = 4;

  // Token store
  localparam int unsigned TOKEN_STORE = 4;
  localparam int unsigned TOKEN_IDX_W = $clog2(TOKEN_STORE);
  localparam logic [2:0]  TOKEN_SAT   = 3'd5;

  // Status codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_LENGTH    = 3'd2;
  localparam logic [2:0] ERR_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ERR_NO_BYTES  = 3'd4;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Characters
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_UX    = 8'h58;

  // One result word
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [2:0] error_code;
    logic       last;
  } result_t;

  // Up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_push_t;

  // Whitespace, comma or semicolon
  function automatic logic is_separator(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]}) ||
           (c == CHAR_COMMA) || (c == CHAR_SEMI);
  endfunction

  // 0..15 for a hex digit, 16 otherwise (bit 4 flags a non-digit)
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      d = {1'b0, c[3:0]};
    end else if (c inside {[CHAR_LA:CHAR_LF_HEX], [CHAR_UA:CHAR_UF]}) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

>>> rtl/hbl_if.sv
// Channel interfaces for the hex byte list parser: character input and result output.
`timescale 1ns / 1ps
interface hbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface hbl_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output byte_value, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input error_code,
                  input last, output ready);
endinterface

>>> rtl/hbl_result_fifo.sv
// Result queue: takes up to two result words a cycle, hands out one a cycle while pop_ready is high.
`timescale 1ns / 1ps
module hbl_result_fifo #(
  parameter int unsigned Depth = hbl_pkg::RESULT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbl_pkg::result_push_t push,
  output logic                 room_two,
  output logic                 pop_valid,
  output hbl_pkg::result_t     pop_data,
  input  logic                 pop_ready
);
  import hbl_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW-1:0] wr_ptr_b;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  // Status and read side
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign room_two  = (count_r <= CntW'(Depth - 2));

  // Pointer and fill count update
  assign wr_ptr_b   = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + PtrW'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
  assign count_nxt  = count_r + CntW'(push.count) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: first word at the write pointer, second right after it
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_b] <= push.second;
    end
  end

endmodule

>>> rtl/hex_byte_list_parser.sv
// A result word is registered into the result queue from the character that causes it.
// Throughput: one character per cycle while in ready is high; an end marker that flushes a
//   byte makes two words, which leave the result queue one at a time.
// in ready drops while the queue has fewer than two free entries.
// Reset (synchronous, rst_n low) clears the token, the latched error and the queue.
`timescale 1ns / 1ps
module hex_byte_list_parser #(
  parameter int unsigned ResultDepth = hbl_pkg::RESULT_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  hbl_in_if.sink   in_ch,
  hbl_out_if.source out_ch
);
  import hbl_pkg::*;

  // Token and text state
  logic [2:0]  len_r, len_nxt;
  logic [7:0]  chars_r [TOKEN_STORE];
  logic [2:0]  err_r, err_nxt;
  logic        seen_r, seen_nxt;
  logic        chars_we;

  logic        accept;
  logic [7:0]  c;
  logic        eot;
  logic [4:0]  c_digit;
  logic        c_is_x;

  // Flush evaluation of the held token
  logic        has_prefix;
  logic [2:0]  eff_len;
  logic [4:0]  d_hi, d_lo;
  logic        tok_active;
  logic        good;
  logic [7:0]  tok_value;
  logic        tok_byte;
  logic [2:0]  tok_err;
  logic [2:0]  err_after;
  logic [2:0]  status_err;

  logic        push_byte, push_status;
  result_t     byte_item, status_item;
  result_push_t push;

  result_t     pop_data;
  logic        room_two;

  assign accept  = in_ch.valid && in_ch.ready;
  assign c       = in_ch.char_code;
  assign eot     = in_ch.end_of_text;
  assign c_digit = digit_value(c);
  assign c_is_x  = (c == CHAR_LX) || (c == CHAR_UX);

  // Optional 0x prefix, only dropped when something follows it
  assign has_prefix = (len_r > 3'd2) && (chars_r[0] == CHAR_ZERO) &&
                      ((chars_r[1] == CHAR_LX) || (chars_r[1] == CHAR_UX));
  assign eff_len    = has_prefix ? (len_r - 3'd2) : len_r;
  assign d_hi       = digit_value(has_prefix ? chars_r[2] : chars_r[0]);
  assign d_lo       = digit_value(has_prefix ? chars_r[3] : chars_r[1]);

  always_comb begin
    good      = 1'b0;
    tok_value = 8'h00;
    case (eff_len)
      3'd1: begin
        good      = !d_hi[4];
        tok_value = {4'h0, d_hi[3:0]};
      end
      3'd2: begin
        good      = !d_hi[4] && !d_lo[4];
        tok_value = {d_hi[3:0], d_lo[3:0]};
      end
      default: begin
        good      = 1'b0;
        tok_value = 8'h00;
      end
    endcase
  end

  assign tok_active = (len_r != 3'd0) && (err_r == ERR_NONE);
  assign tok_byte   = tok_active && good;

  always_comb begin
    tok_err = ERR_NONE;
    if (tok_active) begin
      if ((eff_len == 3'd0) || (eff_len > 3'd2)) begin
        tok_err = ERR_LENGTH;
      end else if (!good) begin
        tok_err = ERR_BAD_DIGIT;
      end
    end
  end

  // Final status at the end marker
  assign err_after  = (tok_err != ERR_NONE) ? tok_err : err_r;
  always_comb begin
    if (err_after != ERR_NONE) begin
      status_err = err_after;
    end else if (seen_r || tok_byte) begin
      status_err = ERR_NONE;
    end else begin
      status_err = ERR_NO_BYTES;
    end
  end

  // Per-character state update
  always_comb begin
    len_nxt     = len_r;
    err_nxt     = err_r;
    seen_nxt    = seen_r;
    chars_we    = 1'b0;
    push_byte   = 1'b0;
    push_status = 1'b0;
    if (accept) begin
      if (eot) begin
        push_byte   = tok_byte;
        push_status = 1'b1;
        len_nxt     = 3'd0;
        err_nxt     = ERR_NONE;
        seen_nxt    = 1'b0;
      end else if (err_r != ERR_NONE) begin
        // characters after an error are dropped
      end else if (is_separator(c)) begin
        push_byte = tok_byte;
        len_nxt   = 3'd0;
        err_nxt   = tok_err;
        seen_nxt  = seen_r || tok_byte;
      end else if (c_digit[4] && !c_is_x) begin
        err_nxt = ERR_BAD_CHAR;
      end else begin
        chars_we = (len_r < 3'(TOKEN_STORE));
        if (len_r < TOKEN_SAT) begin
          len_nxt = len_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 3'd0;
      err_r  <= ERR_NONE;
      seen_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      err_r  <= err_nxt;
      seen_r <= seen_nxt;
    end
  end

  // Token characters, 0x prefix included; only entries below len_r are used
  always_ff @(posedge clk) begin
    if (chars_we) begin
      chars_r[len_r[TOKEN_IDX_W-1:0]] <= c;
    end
  end

  // Result words into the queue, byte first
  assign byte_item   = '{kind: KIND_BYTE, byte_value: tok_value,
                         error_code: ERR_NONE, last: 1'b0};
  assign status_item = '{kind: KIND_STATUS, byte_value: 8'h00,
                         error_code: status_err, last: 1'b1};
  assign push.count  = 2'(push_byte) + 2'(push_status);
  assign push.first  = push_byte ? byte_item : status_item;
  assign push.second = status_item;

  hbl_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_two  (room_two),
    .pop_valid (out_ch.valid),
    .pop_data  (pop_data),
    .pop_ready (out_ch.ready)
  );

  assign in_ch.ready       = room_two;
  assign out_ch.kind       = pop_data.kind;
  assign out_ch.byte_value = pop_data.byte_value;
  assign out_ch.error_code = pop_data.error_code;
  assign out_ch.last       = pop_data.last;

endmodule

>>> rtl/hbl_checker.sv
// Port-level checks for the hex byte list parser, bound to the top level.
`timescale 1ns / 1ps
`include "hex_byte_list_parser_macros.svh"
module hbl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_text,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_byte_value,
  input logic [2:0] out_error_code,
  input logic       out_last
);
  import hbl_pkg::*;

  // An accepted end marker always leaves a word waiting on the next cycle
  `HBL_ASSERT_NEXT(a_eot_gives_word, in_valid && in_ready && in_end_of_text, out_valid)

  // Status word shape
  `HBL_ASSERT_IMPL(a_status_form, out_valid && (out_kind == KIND_STATUS), out_last && (out_byte_value == 8'h00) && (out_error_code <= ERR_NO_BYTES))

  // Byte word shape
  `HBL_ASSERT_IMPL(a_byte_form, out_valid && (out_kind == KIND_BYTE), !out_last && (out_error_code == ERR_NONE))

  // A stalled word stays put
  `HBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte_value) && $stable(out_error_code))

endmodule

bind hex_byte_list_parser hbl_checker u_hbl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_end_of_text (in_ch.end_of_text),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_byte_value (out_ch.byte_value),
  .out_error_code (out_ch.error_code),
  .out_last       (out_ch.last)
);
